// ===== src/gnmf_pkg.sv =====
`timescale 1ns / 1ps

package gnmf_pkg;

  localparam int DATA_W      = 16;  // cell and mean width
  localparam int CFG_W       = 6;   // grid_size register width
  localparam int OUT_IDX_W   = 5;   // out_row / out_col width
  localparam int RESET_SIZE  = 32;  // grid_size after reset
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int LEVEL_W     = 3;   // holds 0..QUEUE_DEPTH

  // Arithmetic widths: a column holds up to 3 cells, a window up to 8.
  localparam int COLSUM_W = 18;
  localparam int SUM_W    = 20;
  localparam int MAG_W    = 19;
  localparam int RECIP_W  = 21;
  localparam int PROD_W   = MAG_W + RECIP_W;
  localparam int DIV_SHIFT = 22;
  localparam int QUO_W    = PROD_W - DIV_SHIFT;

  // ceil(2^22 / d), exact for magnitudes below 2^19
  localparam logic [RECIP_W-1:0] RECIP_3 = 21'd1398102;
  localparam logic [RECIP_W-1:0] RECIP_5 = 21'd838861;
  localparam logic [RECIP_W-1:0] RECIP_8 = 21'd524288;

  typedef enum logic [1:0] {
    DIV_3,
    DIV_5,
    DIV_8
  } div_sel_e;

  // One column of the window: rows r-2, r-1, r
  typedef struct packed {
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] mid;
    logic signed [DATA_W-1:0] bot;
  } col_t;

  // Item handed from the front to the back: one column plus what to emit
  typedef struct packed {
    col_t                 data;
    logic                 top_ok;   // row r-2 exists
    logic                 bot_ok;   // row r exists (not the drain row)
    logic                 left_ok;  // column c-2 exists
    logic                 emit_a;   // emit cell (r-1, c-1)
    logic                 emit_b;   // also emit cell (r-1, c) at row end
    logic                 last;     // drain row of a frame
    logic [OUT_IDX_W-1:0] row;      // r-1
    logic [OUT_IDX_W-1:0] col;      // c
  } col_entry_t;

  function automatic logic [1:0] bank_next(logic [1:0] b);
    logic [1:0] n;
    n = (b == 2'd2) ? 2'd0 : b + 2'd1;
    return n;
  endfunction

endpackage

// ===== src/gnmf_front.sv =====
`timescale 1ns / 1ps

module gnmf_front #(
  parameter int MAX_SIZE = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gnmf_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [gnmf_pkg::DATA_W-1:0] in_data_i,
  input  logic [gnmf_pkg::LEVEL_W-1:0]       q_level_i,
  output logic                               push_o,
  output gnmf_pkg::col_entry_t               push_entry_o
);
  import gnmf_pkg::*;

  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam logic [IDX_W-1:0] MAX_LAST = IDX_W'(MAX_SIZE - 1);
  localparam logic [IDX_W-1:0] RST_LAST =
    (RESET_SIZE > MAX_SIZE) ? IDX_W'(MAX_SIZE - 1) : IDX_W'(RESET_SIZE - 1);

  logic [IDX_W-1:0] row_q, row_d, col_q, col_d, last_q, cfg_last;
  logic [1:0]       bank_q, bank_d;
  logic             flush_q, flush_d;
  logic             rd_valid_q;
  logic [LEVEL_W:0] occ;
  logic             room, acc, issue, at_row_end, r_ge1, r_ge2;

  logic signed [DATA_W-1:0] mem0 [MAX_SIZE];
  logic signed [DATA_W-1:0] mem1 [MAX_SIZE];
  logic signed [DATA_W-1:0] mem2 [MAX_SIZE];
  logic signed [DATA_W-1:0] rd0_q, rd1_q, rd2_q, bot_q;
  logic [1:0]               top_bank_q, mid_bank_q;
  col_entry_t               meta_q, meta_d;

  function automatic logic signed [DATA_W-1:0] pick(logic [1:0] b,
      logic signed [DATA_W-1:0] a0, logic signed [DATA_W-1:0] a1,
      logic signed [DATA_W-1:0] a2);
    logic signed [DATA_W-1:0] v;
    v = (b == 2'd0) ? a0 : ((b == 2'd1) ? a1 : a2);
    return v;
  endfunction

  always_comb begin
    if (cfg_wdata_i < CFG_W'(2)) begin
      cfg_last = IDX_W'(1);
    end else if (cfg_wdata_i > CFG_W'(MAX_SIZE)) begin
      cfg_last = MAX_LAST;
    end else begin
      cfg_last = IDX_W'(cfg_wdata_i - CFG_W'(1));
    end
  end

  // Leave room for the item still in the read stage
  assign occ        = {1'b0, q_level_i} + {{LEVEL_W{1'b0}}, rd_valid_q};
  assign room       = occ < (LEVEL_W + 1)'(QUEUE_DEPTH);
  assign in_ready_o = !flush_q && room;
  assign acc        = in_valid_i && in_ready_o;
  assign issue      = acc || (flush_q && room);
  assign at_row_end = (col_q == last_q);
  assign r_ge1      = flush_q || (row_q != '0);
  assign r_ge2      = flush_q || (row_q > IDX_W'(1));

  always_comb begin
    meta_d         = '0;
    meta_d.top_ok  = r_ge2;
    meta_d.bot_ok  = !flush_q;
    meta_d.left_ok = col_q > IDX_W'(1);
    meta_d.emit_a  = r_ge1 && (col_q != '0);
    meta_d.emit_b  = r_ge1 && at_row_end;
    meta_d.last    = flush_q;
    meta_d.row     = flush_q ? OUT_IDX_W'(last_q) : OUT_IDX_W'(row_q - IDX_W'(1));
    meta_d.col     = OUT_IDX_W'(col_q);
  end

  // Raster position; the drain row after the final cell reads as row n
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    bank_d  = bank_q;
    flush_d = flush_q;
    if (issue) begin
      if (!at_row_end) begin
        col_d = col_q + IDX_W'(1);
      end else begin
        col_d = '0;
        if (flush_q) begin
          flush_d = 1'b0;
          row_d   = '0;
          bank_d  = 2'd0;
        end else if (row_q == last_q) begin
          flush_d = 1'b1;
          bank_d  = bank_next(bank_q);
        end else begin
          row_d  = row_q + IDX_W'(1);
          bank_d = bank_next(bank_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      bank_q     <= 2'd0;
      flush_q    <= 1'b0;
      last_q     <= RST_LAST;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= issue;
      if (cfg_we_i) begin
        row_q   <= '0;
        col_q   <= '0;
        bank_q  <= 2'd0;
        flush_q <= 1'b0;
        last_q  <= cfg_last;
      end else begin
        row_q   <= row_d;
        col_q   <= col_d;
        bank_q  <= bank_d;
        flush_q <= flush_d;
      end
    end
  end

  // Three row banks: write the current row, read the two rows above it
  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (bank_q == 2'd0) begin
        mem0[col_q] <= in_data_i;
      end else if (bank_q == 2'd1) begin
        mem1[col_q] <= in_data_i;
      end else begin
        mem2[col_q] <= in_data_i;
      end
    end
    if (issue) begin
      rd0_q      <= mem0[col_q];
      rd1_q      <= mem1[col_q];
      rd2_q      <= mem2[col_q];
      bot_q      <= in_data_i;
      top_bank_q <= bank_next(bank_q);
      mid_bank_q <= bank_next(bank_next(bank_q));
      meta_q     <= meta_d;
    end
  end

  always_comb begin
    push_entry_o          = meta_q;
    push_entry_o.data.top = pick(top_bank_q, rd0_q, rd1_q, rd2_q);
    push_entry_o.data.mid = pick(mid_bank_q, rd0_q, rd1_q, rd2_q);
    push_entry_o.data.bot = bot_q;
  end

  assign push_o = rd_valid_q;

endmodule

// ===== src/gnmf_queue.sv =====
`timescale 1ns / 1ps

module gnmf_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  gnmf_pkg::col_entry_t         push_entry_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output gnmf_pkg::col_entry_t         head_o,
  output logic [gnmf_pkg::LEVEL_W-1:0] level_o
);
  import gnmf_pkg::*;

  col_entry_t          slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [LEVEL_W-1:0]  level_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + LEVEL_W'(1);
      end else if (pop_i && !push_i) begin
        level_q <= level_q - LEVEL_W'(1);
      end
    end
  end

  assign valid_o = (level_q != '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign level_o = level_q;

endmodule

// ===== src/gnmf_back.sv =====
`timescale 1ns / 1ps

module gnmf_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  gnmf_pkg::col_entry_t                 q_head_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [gnmf_pkg::DATA_W-1:0]   out_mean_o,
  output logic [gnmf_pkg::OUT_IDX_W-1:0]       out_row_o,
  output logic [gnmf_pkg::OUT_IDX_W-1:0]       out_col_o,
  output logic                                 out_last_o
);
  import gnmf_pkg::*;

  logic en, issue, sel_b, phase_q;
  col_t win_l_q, win_m_q;

  logic signed [COLSUM_W-1:0] l_sum, m_sum, r_sum;
  logic                       cols3, rows3;
  div_sel_e                   div_sel;

  logic                        s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic signed [COLSUM_W-1:0]  s1_l_q, s1_m_q, s1_r_q;
  div_sel_e                    s1_div_q;
  logic [OUT_IDX_W-1:0]        s1_row_q, s1_col_q, s2_row_q, s2_col_q, s3_row_q, s3_col_q;
  logic                        s1_last_q, s2_last_q, s3_last_q, s2_neg_q, s3_neg_q;
  logic signed [SUM_W-1:0]     total;
  logic [MAG_W-1:0]            mag, s2_mag_q;
  logic [RECIP_W-1:0]          recip, s2_recip_q;
  logic [PROD_W-1:0]           s3_prod_q;
  logic [QUO_W-1:0]            quo, signed_quo;

  function automatic logic signed [COLSUM_W-1:0] col_sum(col_t v, logic top_ok,
      logic bot_ok, logic mid_ok);
    logic signed [COLSUM_W-1:0] s;
    s = (top_ok ? COLSUM_W'(v.top) : '0) + (mid_ok ? COLSUM_W'(v.mid) : '0)
      + (bot_ok ? COLSUM_W'(v.bot) : '0);
    return s;
  endfunction

  // Whole pipe advances unless a result in the output register waits on out_ready_i
  assign en = !out_valid_q || out_ready_i;

  // A row-end column gives two cells: phase 0 the inner one, phase 1 the edge one
  always_comb begin
    issue = 1'b0;
    sel_b = 1'b0;
    pop_o = 1'b0;
    if (en && q_valid_i) begin
      if (!q_head_i.emit_a) begin
        pop_o = 1'b1;
      end else if (!phase_q) begin
        issue = 1'b1;
        pop_o = !q_head_i.emit_b;
      end else begin
        issue = 1'b1;
        sel_b = 1'b1;
        pop_o = 1'b1;
      end
    end
  end

  always_comb begin
    if (sel_b) begin
      l_sum = col_sum(win_m_q, q_head_i.top_ok, q_head_i.bot_ok, 1'b1);
      m_sum = col_sum(q_head_i.data, q_head_i.top_ok, q_head_i.bot_ok, 1'b0);
      r_sum = '0;
      cols3 = 1'b0;
    end else begin
      l_sum = q_head_i.left_ok
            ? col_sum(win_l_q, q_head_i.top_ok, q_head_i.bot_ok, 1'b1) : '0;
      m_sum = col_sum(win_m_q, q_head_i.top_ok, q_head_i.bot_ok, 1'b0);
      r_sum = col_sum(q_head_i.data, q_head_i.top_ok, q_head_i.bot_ok, 1'b1);
      cols3 = q_head_i.left_ok;
    end
    rows3 = q_head_i.top_ok && q_head_i.bot_ok;
    if (cols3 && rows3) begin
      div_sel = DIV_8;
    end else if (cols3 || rows3) begin
      div_sel = DIV_5;
    end else begin
      div_sel = DIV_3;
    end
  end

  always_comb begin
    total = SUM_W'(s1_l_q) + SUM_W'(s1_m_q) + SUM_W'(s1_r_q);
    mag   = total[SUM_W-1] ? MAG_W'(-total) : MAG_W'(total);
    case (s1_div_q)
      DIV_3:   recip = RECIP_3;
      DIV_5:   recip = RECIP_5;
      DIV_8:   recip = RECIP_8;
      default: recip = RECIP_8;
    endcase
  end

  assign quo        = s3_prod_q[PROD_W-1:DIV_SHIFT];
  assign signed_quo = s3_neg_q ? -quo : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      if (q_valid_i) begin
        phase_q <= q_head_i.emit_a && q_head_i.emit_b && !phase_q;
      end
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      win_l_q <= win_m_q;
      win_m_q <= q_head_i.data;
    end
    if (en) begin
      s1_l_q     <= l_sum;
      s1_m_q     <= m_sum;
      s1_r_q     <= r_sum;
      s1_div_q   <= div_sel;
      s1_row_q   <= q_head_i.row;
      s1_col_q   <= sel_b ? q_head_i.col : q_head_i.col - OUT_IDX_W'(1);
      s1_last_q  <= sel_b && q_head_i.last;
      s2_mag_q   <= mag;
      s2_neg_q   <= total[SUM_W-1];
      s2_recip_q <= recip;
      s2_row_q   <= s1_row_q;
      s2_col_q   <= s1_col_q;
      s2_last_q  <= s1_last_q;
      s3_prod_q  <= PROD_W'(s2_mag_q) * PROD_W'(s2_recip_q);
      s3_neg_q   <= s2_neg_q;
      s3_row_q   <= s2_row_q;
      s3_col_q   <= s2_col_q;
      s3_last_q  <= s2_last_q;
      out_mean_o <= DATA_W'(signed_quo);
      out_row_o  <= s3_row_q;
      out_col_o  <= s3_col_q;
      out_last_o <= s3_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/grid_neighbor_mean_filter_unit.sv =====
`timescale 1ns / 1ps

// A result passes the front's read register, the queue, the back's stages s1, s2
// and s3 and its output register. Throughput: one item per cycle while the queue
// has room; the back part emits two results for a row-end column, so a long
// stream is held back by it. After the last cell of a frame input holds while
// the front re-reads the last two rows to drain them.
// Reset (rst_ni low, asynchronous): grid size 32 (MAX_SIZE if smaller), position (0,0), pipe empty.

module grid_neighbor_mean_filter_unit #(
  parameter int MAX_SIZE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // grid_size register write
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] cell_value
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] mean_value, [20:16] out_row,
                                      // [25:21] out_col, [31:26] zero
  output logic        m_axis_tlast    // frame_last
);
  import gnmf_pkg::*;

  logic                     push, pop, q_valid;
  col_entry_t               push_entry, q_head;
  logic [LEVEL_W-1:0]       q_level;
  logic signed [DATA_W-1:0] mean;
  logic [OUT_IDX_W-1:0]     out_row, out_col;

  // Front: count the raster position, keep the three row banks, and turn every
  // item, and every drain-row position, into one column of three cells plus what the back must emit for it.
  gnmf_front #(
    .MAX_SIZE(MAX_SIZE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .q_level_i   (q_level),
    .push_o      (push),
    .push_entry_o(push_entry)
  );

  // Short queue: lets input keep flowing while the back emits two results
  // for a row-end column or holds on a stalled output.
  gnmf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .level_o     (q_level)
  );

  // Back: slide a three-column window, sum the neighbors that exist, divide
  // by 3, 5 or 8 through a reciprocal multiply, and hold the result.
  gnmf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_mean_o (mean),
    .out_row_o  (out_row),
    .out_col_o  (out_col),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_col, out_row, mean};

endmodule
